@@ rtl/rvjbl_pkg.sv @@
// shared types, opcodes and helpers for the jump/branch/load execute core
`default_nettype none
package rvjbl_pkg;

	localparam int XLEN = 32;
	localparam int NREGS = 32;
	localparam int RIDX_W = 5;
	localparam int QDEPTH = 2;

	localparam logic [6:0] OPC_LUI = 7'h37;
	localparam logic [6:0] OPC_AUIPC = 7'h17;
	localparam logic [6:0] OPC_JAL = 7'h6F;
	localparam logic [6:0] OPC_JALR = 7'h67;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_LOAD = 7'h03;

	localparam logic [2:0] F3_LB = 3'd0;
	localparam logic [2:0] F3_LH = 3'd1;
	localparam logic [2:0] F3_LW = 3'd2;
	localparam logic [2:0] F3_LBU = 3'd4;
	localparam logic [2:0] F3_LHU = 3'd5;

	localparam logic [2:0] F3_BEQ = 3'd0;
	localparam logic [2:0] F3_BNE = 3'd1;
	localparam logic [2:0] F3_BLT = 3'd4;
	localparam logic [2:0] F3_BGE = 3'd5;
	localparam logic [2:0] F3_BLTU = 3'd6;
	localparam logic [2:0] F3_BGEU = 3'd7;

	// item class decided by the front end
	typedef enum logic [1:0] {
		CLS_INSN = 2'd0,
		CLS_LDATA = 2'd1
	} item_cls_t;

	// classified item handed from front to back
	typedef struct packed {
		item_cls_t cls;
		logic [6:0] opc;
		logic [2:0] f3;
		logic [4:0] rd;
		logic [4:0] rs1;
		logic [4:0] rs2;
		logic [31:0] word;
	} dec_item_t;

	function automatic logic [31:0] imm_i(input logic [31:0] w);
		return {{20{w[31]}}, w[31:20]};
	endfunction

	function automatic logic [31:0] imm_b(input logic [31:0] w);
		return {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
	endfunction

	function automatic logic [31:0] imm_j(input logic [31:0] w);
		return {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
	endfunction

	function automatic logic [31:0] load_extract(input logic [2:0] code,
			input logic [31:0] w);
		case (code)
			F3_LB: return {{24{w[7]}}, w[7:0]};
			F3_LH: return {{16{w[15]}}, w[15:0]};
			F3_LBU: return {24'd0, w[7:0]};
			F3_LHU: return {16'd0, w[15:0]};
			default: return w;
		endcase
	endfunction

endpackage
`default_nettype wire

@@ rtl/rv32i_jump_branch_load_core_unit.sv @@
// RV32I jump/branch/load execute core: top level
// result path: an accepted input is written to a queue entry, then executed into the output register
// throughput: one item per cycle while out_ready holds; execution reads and updates the flop register file
// in the same cycle, so back-to-back dependent items run without stall
// reset: arst_n clears pc, pending load, valid bits of all registers and queue
// registers not written since reset read as zero
`default_nettype none
module rv32i_jump_branch_load_core_unit import rvjbl_pkg::*; #(
	parameter int QueueDepth = QDEPTH
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic op,
	input wire logic [31:0] word,
	output logic out_valid,
	input wire logic out_ready,
	output logic req_kind,
	output logic [31:0] req_addr,
	output logic wr_en,
	output logic [4:0] wr_reg,
	output logic [31:0] wr_value
);
	logic q_valid, q_ready;
	dec_item_t q_item;

	// classify and queue
	rvjbl_front #(.Depth(QueueDepth)) u_front (
		.clk, .arst_n, .in_valid, .in_ready,
		.in_op(op), .in_word(word),
		.q_valid, .q_ready, .q_item
	);

	// execute
	rvjbl_back u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_item,
		.out_valid, .out_ready, .req_kind, .req_addr,
		.wr_en, .wr_reg, .wr_value
	);

endmodule
`default_nettype wire

@@ rtl/rvjbl_front.sv @@
// front end: accepts items, splits instruction fields, queues them
`default_nettype none
module rvjbl_front import rvjbl_pkg::*; #(
	parameter int Depth = QDEPTH
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic in_op,
	input wire logic [31:0] in_word,
	output logic q_valid,
	input wire logic q_ready,
	output dec_item_t q_item
);
	localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;

	dec_item_t mem_q [Depth];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0] cnt_q;
	logic push, pop;
	dec_item_t dec;

	// field split
	always_comb begin
		dec.cls = in_op ? CLS_LDATA : CLS_INSN;
		dec.opc = in_word[6:0];
		dec.f3 = in_word[14:12];
		dec.rd = in_word[11:7];
		dec.rs1 = in_word[19:15];
		dec.rs2 = in_word[24:20];
		dec.word = in_word;
	end

	assign in_ready = (cnt_q != (PW+1)'(Depth));
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != '0);
	assign pop = q_valid && q_ready;
	assign q_item = mem_q[rp_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= dec;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(Depth - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(Depth - 1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

	overflow_a: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (PW+1)'(Depth)) else $error("queue count overflow");
	nopush_full_a: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == (PW+1)'(Depth)) |-> !push) else $error("push into full queue");
	count_step_a: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1)) else $error("count step");

endmodule
`default_nettype wire

@@ rtl/rvjbl_back.sv @@
// back end: register file, pc, execution and output register
`default_nettype none
module rvjbl_back import rvjbl_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_valid,
	output logic q_ready,
	input wire dec_item_t q_item,
	output logic out_valid,
	input wire logic out_ready,
	output logic req_kind,
	output logic [31:0] req_addr,
	output logic wr_en,
	output logic [4:0] wr_reg,
	output logic [31:0] wr_value
);
	logic [31:0] rf_q [NREGS];
	logic [NREGS-1:0] rf_vld_q;
	logic [31:0] pc_q;
	logic ld_wait_q;
	logic [4:0] ld_dest_q;
	logic [2:0] ld_code_q;
	logic ov_q;

	logic [31:0] a, b, nxt, val, addr;
	logic kind, wr, taken, ld_ok, exec;
	logic [4:0] rd;

	assign q_ready = !ov_q || out_ready;
	assign exec = q_valid && q_ready;
	assign a = (q_item.rs1 != '0 && rf_vld_q[q_item.rs1]) ? rf_q[q_item.rs1] : '0;
	assign b = (q_item.rs2 != '0 && rf_vld_q[q_item.rs2]) ? rf_q[q_item.rs2] : '0;

	// branch compare and load funct3 check
	always_comb begin
		case (q_item.f3)
			F3_BEQ: taken = (a == b);
			F3_BNE: taken = (a != b);
			F3_BLT: taken = ($signed(a) < $signed(b));
			F3_BGE: taken = ($signed(a) >= $signed(b));
			F3_BLTU: taken = (a < b);
			F3_BGEU: taken = (a >= b);
			default: taken = 1'b0;
		endcase
		ld_ok = (q_item.f3 inside {F3_LB, F3_LH, F3_LW, F3_LBU, F3_LHU});
	end

	// execute
	always_comb begin
		kind = 1'b0;
		wr = 1'b0;
		rd = '0;
		val = '0;
		nxt = pc_q;
		addr = pc_q;
		if (q_item.cls == CLS_LDATA) begin
			if (ld_wait_q) begin
				wr = 1'b1;
				rd = ld_dest_q;
				val = load_extract(ld_code_q, q_item.word);
			end
		end else begin
			nxt = pc_q + 32'd4;
			case (q_item.opc)
				OPC_LUI: begin
					wr = 1'b1; rd = q_item.rd; val = {q_item.word[31:12], 12'd0};
				end
				OPC_AUIPC: begin
					wr = 1'b1; rd = q_item.rd;
					val = {q_item.word[31:12], 12'd0} + pc_q;
				end
				OPC_JAL: begin
					wr = 1'b1; rd = q_item.rd; val = pc_q + 32'd4;
					nxt = pc_q + imm_j(q_item.word);
				end
				OPC_JALR: begin
					wr = 1'b1; rd = q_item.rd; val = pc_q + 32'd4;
					nxt = (a + imm_i(q_item.word)) & 32'hFFFF_FFFE;
				end
				OPC_BRANCH: begin
					if (taken) nxt = pc_q + imm_b(q_item.word);
				end
				OPC_LOAD: begin
					kind = ld_ok;
				end
				default: begin
				end
			endcase
			addr = kind ? (a + imm_i(q_item.word)) : nxt;
		end
		if (rd == '0) begin
			wr = 1'b0;
			val = '0;
		end
	end

	// architectural state and output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
			rf_vld_q <= '0;
			ld_wait_q <= 1'b0;
			ld_dest_q <= '0;
			ld_code_q <= '0;
			ov_q <= 1'b0;
		end else begin
			if (exec) begin
				ov_q <= 1'b1;
				pc_q <= nxt;
				ld_wait_q <= (q_item.cls == CLS_INSN) && kind;
				if ((q_item.cls == CLS_INSN) && kind) begin
					ld_dest_q <= q_item.rd;
					ld_code_q <= q_item.f3;
				end
				if (wr) rf_vld_q[rd] <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// register data and output payload
	always_ff @(posedge clk) begin
		if (exec) begin
			if (wr) rf_q[rd] <= val;
			req_kind <= kind;
			req_addr <= addr;
			wr_en <= wr;
			wr_reg <= rd;
			wr_value <= val;
		end
	end

	assign out_valid = ov_q;

	x0_a: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !wr_en) |-> (wr_reg == '0 && wr_value == '0)) else $error("x0 write");
	hold_a: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid) else $error("output dropped");
	ld_a: assert property (@(posedge clk) disable iff (!arst_n)
		(exec && kind) |=> ld_wait_q) else $error("load not pending");

endmodule
`default_nettype wire
